@@ design/imufr_pkg.sv @@
package imufr_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int FRAME_BYTES   = PAYLOAD_BYTES + 3;
    localparam int POS_W         = $clog2(FRAME_BYTES + 1);
    localparam int PIDX_W        = $clog2(PAYLOAD_BYTES);
    localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
    localparam int SCALE_W       = 11;
    localparam int SCALED_W      = 27;
    localparam int YEAR_W        = 12;

    localparam logic [7:0] ID_FIRST = 8'h50;
    localparam logic [7:0] ID_LAST  = 8'h5A;

    localparam logic [3:0] KIND_ACCEL = 4'd1;
    localparam logic [3:0] KIND_GYRO  = 4'd2;
    localparam logic [3:0] KIND_ANGLE = 4'd3;

    localparam logic CFG_ACCEL_RANGE = 1'b0;
    localparam logic CFG_GYRO_RANGE  = 1'b1;

    localparam logic [SCALE_W-1:0]  ANGLE_FULL_SCALE = SCALE_W'(180);
    localparam logic [YEAR_W-1:0]   YEAR_BASE        = YEAR_W'(2000);

    typedef struct packed {
        logic [1:0] accel_range_sel;
        logic [1:0] gyro_range_sel;
    } t_cfg;

    typedef struct packed {
        logic                 valid;
        logic [3:0]           kind;
        logic [PAYLOAD_W-1:0] payload;
        logic [SCALE_W-1:0]   scale;
    } t_frame;

    function automatic logic [SCALE_W-1:0] accel_scale(input logic [1:0] sel);
        logic [SCALE_W-1:0] s;
        unique case (sel)
            2'd0:    s = SCALE_W'(2);
            2'd1:    s = SCALE_W'(4);
            2'd2:    s = SCALE_W'(8);
            default: s = SCALE_W'(16);
        endcase
        return s;
    endfunction

    function automatic logic [SCALE_W-1:0] gyro_scale(input logic [1:0] sel);
        logic [SCALE_W-1:0] s;
        unique case (sel)
            2'd0:    s = SCALE_W'(250);
            2'd1:    s = SCALE_W'(500);
            2'd2:    s = SCALE_W'(1000);
            default: s = SCALE_W'(2000);
        endcase
        return s;
    endfunction

endpackage

@@ design/imufr_if.sv @@
interface imufr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       restart;

    modport source (output valid, output rx_byte, output restart, input ready);
    modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

interface imufr_out_if;
    logic               valid;
    logic               ready;
    logic        [3:0]  frame_kind;
    logic signed [15:0] word0;
    logic signed [15:0] word1;
    logic signed [15:0] word2;
    logic signed [15:0] word3;
    logic signed [31:0] long_lo;
    logic signed [31:0] long_hi;
    logic signed [26:0] scaled_x;
    logic signed [26:0] scaled_y;
    logic signed [26:0] scaled_z;
    logic        [11:0] year;

    modport source (output valid, output frame_kind, output word0, output word1,
                    output word2, output word3, output long_lo, output long_hi,
                    output scaled_x, output scaled_y, output scaled_z, output year,
                    input ready);
    modport sink   (input valid, input frame_kind, input word0, input word1,
                    input word2, input word3, input long_lo, input long_hi,
                    input scaled_x, input scaled_y, input scaled_z, input year,
                    output ready);
endinterface

@@ design/imufr_framer.sv @@
module imufr_framer import imufr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_restart,
    input  t_cfg       i_cfg,
    input  logic       i_take,
    output logic       o_ready,
    output t_frame     o_frame
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_id;
    logic [7:0]       r_payload [PAYLOAD_BYTES];

    logic                 r_frame_valid;
    logic [3:0]           r_frame_kind;
    logic [PAYLOAD_W-1:0] r_frame_payload;
    logic [SCALE_W-1:0]   r_frame_scale;

    logic [POS_W-1:0]  pos;
    logic [PIDX_W-1:0] pidx;
    logic              beat;
    logic              is_check;
    logic              good;
    logic [3:0]        kind;
    logic [SCALE_W-1:0] scale;
    logic [PAYLOAD_W-1:0] packed_payload;

    assign o_ready = !r_frame_valid || i_take;
    assign beat    = i_valid && o_ready;
    assign o_frame = {r_frame_valid, r_frame_kind, r_frame_payload, r_frame_scale};

    always_comb begin
        pos = i_restart ? '0 : r_pos;
        if (pos >= POS_W'(FRAME_BYTES)) begin
            pos = '0;
        end
        is_check = (pos == POS_W'(FRAME_BYTES - 1));
        pidx     = PIDX_W'(pos - POS_W'(2));
        n_sum    = (pos == '0) ? i_rx_byte : r_sum + i_rx_byte;
        n_pos    = is_check ? '0 : pos + POS_W'(1);
        good     = (i_rx_byte == r_sum) && (r_id >= ID_FIRST) && (r_id <= ID_LAST);
        kind     = 4'(r_id - ID_FIRST);
        priority if (kind == KIND_ACCEL) begin
            scale = accel_scale(i_cfg.accel_range_sel);
        end else if (kind == KIND_GYRO) begin
            scale = gyro_scale(i_cfg.gyro_range_sel);
        end else if (kind == KIND_ANGLE) begin
            scale = ANGLE_FULL_SCALE;
        end else begin
            scale = '0;
        end
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            packed_payload[8*i +: 8] = r_payload[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_sum         <= '0;
            r_frame_valid <= 1'b0;
        end else begin
            if (i_take) begin
                r_frame_valid <= 1'b0;
            end
            if (beat) begin
                r_pos <= n_pos;
                if (!is_check) begin
                    r_sum <= n_sum;
                end
                if (is_check && good) begin
                    r_frame_valid <= 1'b1;
                end
            end
        end
    end

    // payload side, no reset
    always_ff @(posedge i_clk) begin
        if (beat) begin
            if (pos == POS_W'(1)) begin
                r_id <= i_rx_byte;
            end else if (pos >= POS_W'(2) && !is_check) begin
                r_payload[pidx] <= i_rx_byte;
            end
            if (is_check) begin
                r_frame_kind    <= kind;
                r_frame_payload <= packed_payload;
                r_frame_scale   <= scale;
            end
        end
    end

endmodule

@@ design/imu_frame_receiver_core.sv @@
// imu_frame_receiver_core: parser for 11-byte imu frames with a sum checksum
// i_in carries one serial byte per beat with a restart flag that forces the
// byte to be frame byte 0; o_out carries one decoded result per good frame
// with id 0x50..0x5a: kind, four signed words, two signed longs, the year
// and three axes scaled by full scale with 15 fraction bits
// range selects are written on i_cfg_we/i_cfg_idx/i_cfg_data (0 accel, 1 gyro)
// one byte is taken per cycle while i_in.ready is high; the result of a good
// frame passes first through the frame register of the framer, then through
// the output register behind the scaling multipliers
// the frame register and the output register each hold one result, so bytes
// keep flowing while a result waits; when both are full, i_in.ready drops
// until o_out.ready takes the waiting result
// reset clears the byte position, the running sum, both valid flags and sets
// the ranges to 16 g and 2000 deg/s; a partial frame is simply dropped
module imu_frame_receiver_core import imufr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    imufr_in_if.sink    i_in,
    imufr_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [1:0]  i_cfg_data
);

    t_cfg   r_cfg;
    t_frame frame;
    logic   take;

    logic r_o_valid;
    logic [3:0]          r_kind;
    logic [PAYLOAD_W-1:0] r_payload;
    logic signed [SCALED_W-1:0] r_sx, r_sy, r_sz;
    logic [YEAR_W-1:0]   r_year;

    logic signed [SCALE_W:0]        scale_s;
    logic signed [SCALE_W+16:0]     prod_x, prod_y, prod_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_range_sel <= 2'd3;
            r_cfg.gyro_range_sel  <= 2'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACCEL_RANGE: r_cfg.accel_range_sel <= i_cfg_data;
                CFG_GYRO_RANGE:  r_cfg.gyro_range_sel  <= i_cfg_data;
            endcase
        end
    end

    assign take = !r_o_valid || o_out.ready;

    imufr_framer u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_rx_byte (i_in.rx_byte),
        .i_restart (i_in.restart),
        .i_cfg     (r_cfg),
        .i_take    (take),
        .o_ready   (i_in.ready),
        .o_frame   (frame)
    );

    always_comb begin
        scale_s = $signed({1'b0, frame.scale});
        prod_x  = $signed(frame.payload[15:0])  * scale_s;
        prod_y  = $signed(frame.payload[31:16]) * scale_s;
        prod_z  = $signed(frame.payload[47:32]) * scale_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (take) begin
            r_o_valid <= frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && frame.valid) begin
            r_kind    <= frame.kind;
            r_payload <= frame.payload;
            r_sx      <= prod_x[SCALED_W-1:0];
            r_sy      <= prod_y[SCALED_W-1:0];
            r_sz      <= prod_z[SCALED_W-1:0];
            r_year    <= YEAR_BASE + YEAR_W'(frame.payload[7:0]);
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.frame_kind = r_kind;
    assign o_out.word0      = r_payload[15:0];
    assign o_out.word1      = r_payload[31:16];
    assign o_out.word2      = r_payload[47:32];
    assign o_out.word3      = r_payload[63:48];
    assign o_out.long_lo    = r_payload[31:0];
    assign o_out.long_hi    = r_payload[63:32];
    assign o_out.scaled_x   = r_sx;
    assign o_out.scaled_y   = r_sy;
    assign o_out.scaled_z   = r_sz;
    assign o_out.year       = r_year;

endmodule
